/* design/htw_pkg.sv */
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and constants for the hierarchical timing wheel.
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

    localparam int IDX_W  = 7;
    localparam int LEVELS = 4;

    localparam logic [IDX_W-1:0] NIL = 7'h7F;

    localparam logic [1:0] ST_ACCEPT  = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_EXPIRED = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [30:0] delay;
        logic [31:0] tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] expired_tag;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic        is_tick;
        logic [30:0] delay;
        logic [31:0] tag;
    } fe_item_t;

    typedef struct packed {
        logic pop;
        logic init_done;
    } be_ctl_t;

endpackage

`default_nettype wire

/* design/htw_chan_if.sv */
// ----------------------------------------------------------------------------
// htw_chan_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface htw_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/htw_ram.sv */
// ----------------------------------------------------------------------------
// htw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wa,
    input  wire logic [WIDTH-1:0] wd,
    input  wire logic             re,
    input  wire logic [AW-1:0]    ra,
    output logic      [WIDTH-1:0] rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd <= mem[ra];
        end
    end

endmodule

`default_nettype wire

/* design/htw_front.sv */
// ----------------------------------------------------------------------------
// htw_front
// Input queue: accept words, classify add or tick, hand them to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_front
    import htw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    htw_chan_if.sink      req,
    input  wire be_ctl_t  ctl,
    output fe_item_t      item
);

    fe_item_t   q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign req.ready = (cnt_reg != 2'd2) && ctl.init_done;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        item       = q_reg[rp_reg];
        item.valid = (cnt_reg != 2'd0);
    end

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = ctl.pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, ctl.pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= '{valid: 1'b1, is_tick: req.data.kind,
                               delay: req.data.delay, tag: req.data.tag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* design/htw_back.sv */
// ----------------------------------------------------------------------------
// htw_back
// Wheel engine: slot lists, entry pool, cascade, expiry and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_back
    import htw_pkg::*;
#(
    parameter int NEAR_BITS    = 8,
    parameter int LEVEL_BITS   = 6,
    parameter int POOL_ENTRIES = 64,
    parameter int TAG_BITS     = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fe_item_t item,
    output be_ctl_t       ctl,
    htw_chan_if.source    rsp
);

    localparam int NEAR_SLOTS  = 1 << NEAR_BITS;
    localparam int LEVEL_SLOTS = 1 << LEVEL_BITS;
    localparam int SLOTS       = NEAR_SLOTS + LEVELS * LEVEL_SLOTS;
    localparam int SA_W        = $clog2(SLOTS);
    localparam int PA_W        = $clog2(POOL_ENTRIES);
    localparam int EW          = 32 + TAG_BITS;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADD_NX   = 4'd2;
    localparam logic [3:0] S_FILE     = 4'd3;
    localparam logic [3:0] S_FILE_RD  = 4'd4;
    localparam logic [3:0] S_FILE_LNK = 4'd5;
    localparam logic [3:0] S_X_RD     = 4'd6;
    localparam logic [3:0] S_X_LOOP   = 4'd7;
    localparam logic [3:0] S_X_GOT    = 4'd8;
    localparam logic [3:0] S_ADV      = 4'd9;
    localparam logic [3:0] S_C_RD     = 4'd10;
    localparam logic [3:0] S_C_LOOP   = 4'd11;
    localparam logic [3:0] S_C_GOT    = 4'd12;
    localparam logic [3:0] S_EXP2     = 4'd13;
    localparam logic [3:0] S_END      = 4'd14;

    localparam logic [IDX_W-1:0] POOL_IDX = IDX_W'(POOL_ENTRIES);

    logic [3:0]          state_reg, state_next;
    logic [SA_W-1:0]     cnt_reg, cnt_next;
    logic [31:0]         now_reg, now_next;
    logic [IDX_W-1:0]    free_reg, free_next;
    logic [IDX_W-1:0]    e_reg, e_next;
    logic [IDX_W-1:0]    nx_reg, nx_next;
    logic [IDX_W-1:0]    lnk_reg, lnk_next;
    logic [31:0]         exp_reg, exp_next;
    logic [SA_W-1:0]     slot_reg, slot_next;
    logic                pass_reg, pass_next;
    logic                casc_ret_reg, casc_ret_next;
    logic                pend_v_reg, pend_v_next;
    logic [TAG_BITS-1:0] pend_tag_reg, pend_tag_next;
    logic                out_v_reg, out_v_next;
    out_item_t           out_d_reg, out_d_next;

    logic                sl_we, sl_re;
    logic [SA_W-1:0]     sl_wa, sl_ra;
    logic [2*IDX_W-1:0]  sl_wd, sl_rd;
    logic                nx_we, nx_re;
    logic [PA_W-1:0]     nx_wa, nx_ra;
    logic [IDX_W-1:0]    nx_wd, nx_rd;
    logic                en_we, en_re;
    logic [PA_W-1:0]     en_wa;
    logic [EW-1:0]       en_wd, en_rd;

    logic [IDX_W-1:0]    rd_h, rd_t;
    logic                head_empty;
    logic                can_emit, emit;
    out_item_t           emit_d;
    logic [31:0]         add_exp;
    logic [SA_W-1:0]     near_now_slot;

    logic [SA_W-1:0]       file_slot;
    logic [1:0]            file_lvl;
    logic [LEVEL_BITS-1:0] file_idx [LEVELS];
    logic [63:0]           e64, n64, m64;

    logic [31:0]           ct;
    logic [63:0]           c64, cm64;
    logic [LEVEL_BITS-1:0] ct_idx [LEVELS];
    logic                  casc, stop;
    logic [1:0]            casc_lvl;
    logic [LEVEL_BITS-1:0] casc_idx;
    logic [SA_W-1:0]       casc_slot;

    htw_ram #(.WIDTH(2*IDX_W), .DEPTH(SLOTS)) u_slot_ram (
        .clk(clk), .we(sl_we), .wa(sl_wa), .wd(sl_wd),
        .re(sl_re), .ra(sl_ra), .rd(sl_rd)
    );

    htw_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_next_ram (
        .clk(clk), .we(nx_we), .wa(nx_wa), .wd(nx_wd),
        .re(nx_re), .ra(nx_ra), .rd(nx_rd)
    );

    htw_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_entry_ram (
        .clk(clk), .we(en_we), .wa(en_wa), .wd(en_wd),
        .re(en_re), .ra(nx_ra), .rd(en_rd)
    );

    assign rd_h          = sl_rd[2*IDX_W-1:IDX_W];
    assign rd_t          = sl_rd[IDX_W-1:0];
    assign head_empty    = (rd_h == NIL) || (rd_t >= POOL_IDX);
    assign can_emit      = !out_v_reg || rsp.ready;
    assign add_exp       = now_reg + {1'b0, item.delay};
    assign near_now_slot = SA_W'(now_reg[NEAR_BITS-1:0]);

    assign rsp.valid = out_v_reg;
    assign rsp.data  = out_d_reg;

    always_comb
    begin
        e64      = {32'b0, exp_reg};
        n64      = {32'b0, now_reg};
        file_lvl = 2'd3;
        for (int i = 0; i < LEVELS; i++)
        begin
            file_idx[i] = LEVEL_BITS'(e64 >> (NEAR_BITS + i * LEVEL_BITS));
        end
        for (int i = LEVELS - 2; i >= 0; i--)
        begin
            m64 = (64'd1 << (NEAR_BITS + (i + 1) * LEVEL_BITS)) - 64'd1;
            if ((e64 | m64) == (n64 | m64))
            begin
                file_lvl = 2'(i);
            end
        end
        if (exp_reg[31:NEAR_BITS] == now_reg[31:NEAR_BITS])
        begin
            file_slot = SA_W'(exp_reg[NEAR_BITS-1:0]);
        end
        else
        begin
            file_slot = SA_W'(NEAR_SLOTS) + SA_W'({file_lvl, file_idx[file_lvl]});
        end
    end

    always_comb
    begin
        ct       = now_reg + 32'd1;
        c64      = {32'b0, ct};
        cm64     = '0;
        casc     = 1'b0;
        stop     = 1'b0;
        casc_lvl = 2'd3;
        casc_idx = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            ct_idx[i] = LEVEL_BITS'(c64 >> (NEAR_BITS + i * LEVEL_BITS));
        end
        if (ct == 32'd0)
        begin
            casc = 1'b1;
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                cm64 = (64'd1 << (NEAR_BITS + i * LEVEL_BITS)) - 64'd1;
                if (!stop)
                begin
                    if ((c64 & cm64) == 64'd0)
                    begin
                        if (ct_idx[i] != '0)
                        begin
                            casc     = 1'b1;
                            casc_lvl = 2'(i);
                            casc_idx = ct_idx[i];
                            stop     = 1'b1;
                        end
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
            end
        end
        casc_slot = SA_W'(NEAR_SLOTS) + SA_W'({casc_lvl, casc_idx});
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        now_next      = now_reg;
        free_next     = free_reg;
        e_next        = e_reg;
        nx_next       = nx_reg;
        lnk_next      = lnk_reg;
        exp_next      = exp_reg;
        slot_next     = slot_reg;
        pass_next     = pass_reg;
        casc_ret_next = casc_ret_reg;
        pend_v_next   = pend_v_reg;
        pend_tag_next = pend_tag_reg;

        sl_we = 1'b0;
        sl_wa = slot_reg;
        sl_wd = {NIL, NIL};
        sl_re = 1'b0;
        sl_ra = slot_reg;
        nx_we = 1'b0;
        nx_wa = PA_W'(e_reg);
        nx_wd = NIL;
        nx_re = 1'b0;
        nx_ra = PA_W'(e_reg);
        en_we = 1'b0;
        en_wa = PA_W'(free_reg);
        en_wd = {add_exp, TAG_BITS'({32'b0, item.tag})};
        en_re = 1'b0;

        emit    = 1'b0;
        emit_d  = '{status: ST_EXPIRED, expired_tag: 32'(64'(pend_tag_reg)), last: 1'b0};
        ctl.pop = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                sl_we = 1'b1;
                sl_wa = cnt_reg;
                if ({1'b0, cnt_reg} < (SA_W+1)'(POOL_ENTRIES))
                begin
                    nx_we = 1'b1;
                    nx_wa = PA_W'(cnt_reg);
                    nx_wd = ({1'b0, cnt_reg} + (SA_W+1)'(1) < (SA_W+1)'(POOL_ENTRIES))
                            ? IDX_W'(cnt_reg + SA_W'(1)) : NIL;
                end
                cnt_next = cnt_reg + SA_W'(1);
                if (cnt_reg == SA_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.is_tick)
                    begin
                        ctl.pop    = 1'b1;
                        pass_next  = 1'b0;
                        slot_next  = near_now_slot;
                        sl_re      = 1'b1;
                        sl_ra      = near_now_slot;
                        state_next = S_X_RD;
                    end
                    else if (can_emit)
                    begin
                        ctl.pop = 1'b1;
                        emit    = 1'b1;
                        emit_d  = '{status: ST_ACCEPT, expired_tag: 32'd0, last: 1'b1};
                        if (free_reg >= POOL_IDX)
                        begin
                            emit_d.status = ST_REJECT;
                        end
                        else
                        begin
                            nx_re      = 1'b1;
                            nx_ra      = PA_W'(free_reg);
                            en_we      = 1'b1;
                            e_next     = free_reg;
                            exp_next   = add_exp;
                            state_next = S_ADD_NX;
                        end
                    end
                end
            end
            S_ADD_NX:
            begin
                free_next     = nx_rd;
                casc_ret_next = 1'b0;
                state_next    = S_FILE;
            end
            S_FILE:
            begin
                sl_re      = 1'b1;
                sl_ra      = file_slot;
                slot_next  = file_slot;
                state_next = S_FILE_RD;
            end
            S_FILE_RD:
            begin
                sl_we = 1'b1;
                sl_wd = {head_empty ? e_reg : rd_h, e_reg};
                nx_we = 1'b1;
                if (!head_empty)
                begin
                    lnk_next   = rd_t;
                    state_next = S_FILE_LNK;
                end
                else if (casc_ret_reg)
                begin
                    e_next     = nx_reg;
                    state_next = S_C_LOOP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILE_LNK:
            begin
                nx_we = 1'b1;
                nx_wa = PA_W'(lnk_reg);
                nx_wd = e_reg;
                if (casc_ret_reg)
                begin
                    e_next     = nx_reg;
                    state_next = S_C_LOOP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_X_RD:
            begin
                sl_we      = 1'b1;
                e_next     = rd_h;
                state_next = S_X_LOOP;
            end
            S_X_LOOP:
            begin
                if (e_reg >= POOL_IDX)
                begin
                    state_next = pass_reg ? S_END : S_ADV;
                end
                else
                begin
                    nx_re      = 1'b1;
                    en_re      = 1'b1;
                    state_next = S_X_GOT;
                end
            end
            S_X_GOT:
            begin
                if (!pend_v_reg || can_emit)
                begin
                    emit          = pend_v_reg;
                    pend_v_next   = 1'b1;
                    pend_tag_next = en_rd[TAG_BITS-1:0];
                    nx_we         = 1'b1;
                    nx_wd         = free_reg;
                    free_next     = e_reg;
                    e_next        = nx_rd;
                    state_next    = S_X_LOOP;
                end
            end
            S_ADV:
            begin
                now_next = ct;
                if (casc)
                begin
                    slot_next  = casc_slot;
                    sl_re      = 1'b1;
                    sl_ra      = casc_slot;
                    state_next = S_C_RD;
                end
                else
                begin
                    state_next = S_EXP2;
                end
            end
            S_C_RD:
            begin
                sl_we      = 1'b1;
                e_next     = rd_h;
                state_next = S_C_LOOP;
            end
            S_C_LOOP:
            begin
                if (e_reg >= POOL_IDX)
                begin
                    state_next = S_EXP2;
                end
                else
                begin
                    nx_re      = 1'b1;
                    en_re      = 1'b1;
                    state_next = S_C_GOT;
                end
            end
            S_C_GOT:
            begin
                nx_next       = nx_rd;
                exp_next      = en_rd[EW-1:TAG_BITS];
                casc_ret_next = 1'b1;
                state_next    = S_FILE;
            end
            S_EXP2:
            begin
                pass_next  = 1'b1;
                slot_next  = near_now_slot;
                sl_re      = 1'b1;
                sl_ra      = near_now_slot;
                state_next = S_X_RD;
            end
            S_END:
            begin
                if (!pend_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_emit)
                begin
                    emit        = 1'b1;
                    emit_d.last = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        ctl.init_done = (state_reg != S_INIT);
        out_v_next    = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_v_reg);
        out_d_next    = emit ? emit_d : out_d_reg;
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        nx_reg       <= nx_next;
        lnk_reg      <= lnk_next;
        exp_reg      <= exp_next;
        slot_reg     <= slot_next;
        pend_tag_reg <= pend_tag_next;
        out_d_reg    <= out_d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            now_reg      <= '0;
            free_reg     <= '0;
            pass_reg     <= 1'b0;
            casc_ret_reg <= 1'b0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            now_reg      <= now_next;
            free_reg     <= free_next;
            pass_reg     <= pass_next;
            casc_ret_reg <= casc_ret_next;
            pend_v_reg   <= pend_v_next;
            out_v_reg    <= out_v_next;
        end
    end

endmodule

`default_nettype wire

/* design/hierarchical_timing_wheel_unit.sv */
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel_unit
// Near wheel plus four upper levels of timer lists over a fixed entry pool.
// Add: pool pop, slot read, slot write and, for a non-empty slot, tail link;
// the result word is registered in the cycle after the back end takes the add.
// Tick: expire the near slot, advance now, cascade a due upper-level slot and
// expire the new near slot, walking the lists in the slot and entry RAMs.
// Reset: a clearing pass over NEAR_SLOTS + 4*LEVEL_SLOTS slots (512 at default)
// empties every slot list and chains the free list; req.ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_timing_wheel_unit
    import htw_pkg::*;
#(
    parameter int NEAR_BITS    = 8,
    parameter int LEVEL_BITS   = 6,
    parameter int POOL_ENTRIES = 64,
    parameter int TAG_BITS     = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    htw_chan_if.sink   req,
    htw_chan_if.source rsp
);

    fe_item_t item;
    be_ctl_t  ctl;

    htw_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .item  (item)
    );

    htw_back #(
        .NEAR_BITS    (NEAR_BITS),
        .LEVEL_BITS   (LEVEL_BITS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .TAG_BITS     (TAG_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .ctl   (ctl),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

/* design/htw_checker.sv */
// ----------------------------------------------------------------------------
// htw_checker
// Port-level checks on the timing wheel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_checker
    import htw_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  rsp_status,
    input wire logic [31:0] rsp_tag,
    input wire logic        rsp_last
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tag)
                                    && $stable(rsp_last))
        else $error("response word changed while stalled");

    a_add_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_EXPIRED |-> rsp_last && rsp_tag == 32'd0)
        else $error("add result must be a single word with zero tag");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == ST_ACCEPT || rsp_status == ST_REJECT
                      || rsp_status == ST_EXPIRED)
        else $error("undefined status code");

    a_init_block: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !req_ready)
        else $error("input taken during clearing pass");

endmodule

bind hierarchical_timing_wheel_unit htw_checker u_htw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.data.status),
    .rsp_tag    (rsp.data.expired_tag),
    .rsp_last   (rsp.data.last)
);

`default_nettype wire

/* sim/tb_hierarchical_timing_wheel_unit.sv */
// ----------------------------------------------------------------------------
// tb_hierarchical_timing_wheel_unit
// Self-checking bench for the timing wheel: a short table of directed add and
// tick words, random traffic under varying idle and stall patterns, then a burst of adds. Each
// expired, accepted or rejected word is checked against a behavioral wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hierarchical_timing_wheel_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import htw_pkg::*;

    localparam int NEAR_SLOTS = 256;
    localparam int LVL_SLOTS  = 64;
    localparam int POOL       = 64;
    localparam int RAND_ITEMS = 160;
    localparam int BURST      = 70;

    typedef struct {
        logic        kind;
        logic [30:0] delay;
        logic [31:0] tag;
        bit          typed;
        out_item_t   want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   snd_idle;
    int   rcv_stall;

    htw_chan_if #(.T(in_item_t))  req ();
    htw_chan_if #(.T(out_item_t)) rsp ();

    hierarchical_timing_wheel_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // wheel model
    logic [31:0] now_tick;
    logic [6:0]  near_head [NEAR_SLOTS];
    logic [6:0]  near_tail [NEAR_SLOTS];
    logic [6:0]  lvl_head  [LEVELS*LVL_SLOTS];
    logic [6:0]  lvl_tail  [LEVELS*LVL_SLOTS];
    logic [6:0]  link      [POOL];
    logic [31:0] expiry    [POOL];
    logic [31:0] tagv      [POOL];
    logic [6:0]  free_hd;
    out_item_t   due_q[$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic wheel_clear();
        now_tick = '0;
        for (int i = 0; i < NEAR_SLOTS; i++)
        begin
            near_head[i] = NIL;
            near_tail[i] = NIL;
        end
        for (int i = 0; i < LEVELS*LVL_SLOTS; i++)
        begin
            lvl_head[i] = NIL;
            lvl_tail[i] = NIL;
        end
        for (int i = 0; i < POOL; i++)
        begin
            link[i]   = (i + 1 < POOL) ? 7'(i + 1) : NIL;
            expiry[i] = '0;
            tagv[i]   = '0;
        end
        free_hd = '0;
    endtask

    task automatic file_timer(logic [6:0] e);
        logic [63:0] ex;
        logic [63:0] nw;
        logic [63:0] mask;
        int          lv;
        int          s;
        ex = 64'(expiry[e]);
        nw = 64'(now_tick);
        if ((ex | 64'hFF) == (nw | 64'hFF))
        begin
            s = int'(ex[7:0]);
            link[e] = NIL;
            if (near_head[s] == NIL || near_tail[s] >= POOL)
                near_head[s] = e;
            else
                link[near_tail[s]] = e;
            near_tail[s] = e;
        end
        else
        begin
            mask = 64'd256 << 6;
            lv = 0;
            while (lv < LEVELS - 1 && (ex | (mask - 1)) != (nw | (mask - 1)))
            begin
                mask = mask << 6;
                lv++;
            end
            s = lv * LVL_SLOTS + int'((ex >> (8 + lv*6)) & 64'h3F);
            link[e] = NIL;
            if (lvl_head[s] == NIL || lvl_tail[s] >= POOL)
                lvl_head[s] = e;
            else
                link[lvl_tail[s]] = e;
            lvl_tail[s] = e;
        end
    endtask

    task automatic cascade_slot(int lv, int idx);
        int         s;
        int         guard;
        logic [6:0] e;
        logic [6:0] nx;
        s = lv * LVL_SLOTS + (idx & 63);
        e = lvl_head[s];
        guard = 0;
        lvl_head[s] = NIL;
        lvl_tail[s] = NIL;
        while (e < POOL && guard < POOL)
        begin
            nx = link[e];
            file_timer(e);
            e = nx;
            guard++;
        end
    endtask

    task automatic expire_slot(inout int n);
        int         s;
        logic [6:0] e;
        logic [6:0] nx;
        out_item_t  o;
        s = int'(now_tick[7:0]);
        e = near_head[s];
        near_head[s] = NIL;
        near_tail[s] = NIL;
        while (e < POOL && n < POOL)
        begin
            nx = link[e];
            o.status = ST_EXPIRED;
            o.expired_tag = tagv[e];
            o.last = 1'b0;
            due_q.push_back(o);
            n++;
            link[e] = free_hd;
            free_hd = e;
            e = nx;
        end
    endtask

    task automatic wheel_step(in_item_t it);
        int          n;
        int          lv;
        logic [63:0] mask;
        logic [63:0] t;
        logic [6:0]  e;
        out_item_t   o;
        o.expired_tag = '0;
        o.last = 1'b1;
        if (!it.kind)
        begin
            e = free_hd;
            if (e >= POOL)
            begin
                o.status = ST_REJECT;
            end
            else
            begin
                free_hd = link[e];
                expiry[e] = now_tick + 32'(it.delay);
                tagv[e] = it.tag;
                file_timer(e);
                o.status = ST_ACCEPT;
            end
            due_q.push_back(o);
        end
        else
        begin
            n = 0;
            expire_slot(n);
            now_tick = now_tick + 1;
            if (now_tick == 0)
            begin
                cascade_slot(3, 0);
            end
            else
            begin
                lv = 0;
                mask = 64'd256;
                t = 64'(now_tick) >> 8;
                while (lv < LEVELS && (64'(now_tick) & (mask - 1)) == 0)
                begin
                    if ((t & 64'h3F) != 0)
                    begin
                        cascade_slot(lv, int'(t & 64'h3F));
                        break;
                    end
                    mask = mask << 6;
                    t = t >> 6;
                    lv++;
                end
            end
            expire_slot(n);
            if (n > 0)
                due_q[$].last = 1'b1;
        end
    endtask

    task automatic send_word(in_item_t it, bit typed, out_item_t want);
        int depth;
        while (snd_idle > 0 && $urandom_range(99) < snd_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        depth = due_q.size();
        wheel_step(it);
        if (typed)
        begin
            while (due_q.size() > depth)
                void'(due_q.pop_back());
            due_q.push_back(want);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rcv_stall > 0)
            rsp.ready <= ($urandom_range(99) >= rcv_stall);
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (due_q.size() == 0)
            begin
                $display("%0t: unexpected word status=%0d tag=%h last=%0d", $time,
                         rsp.data.status, rsp.data.expired_tag, rsp.data.last);
                errors++;
            end
            else
            begin
                w = due_q.pop_front();
                if (rsp.data.status !== w.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, w.status,
                             rsp.data.status);
                    errors++;
                end
                if (rsp.data.expired_tag !== w.expired_tag)
                begin
                    $display("%0t: expired_tag expected %h actual %h", $time,
                             w.expired_tag, rsp.data.expired_tag);
                    errors++;
                end
                if (rsp.data.last !== w.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, w.last,
                             rsp.data.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        dir_row_t  rows[$];
        dir_row_t  r;
        in_item_t  it;
        out_item_t acc;
        out_item_t none;
        int        roll;

        errors = 0;
        snd_idle = 0;
        rcv_stall = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        wheel_clear();

        acc.status = ST_ACCEPT;
        acc.expired_tag = '0;
        acc.last = 1'b1;
        none = '0;
        rows = '{
            '{1'b0, 31'd0,          32'h0000_0000, 1'b1, acc},
            '{1'b0, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b1, acc},
            '{1'b0, 31'd1,          32'hA5A5_A5A5, 1'b1, acc},
            '{1'b0, 31'd1,          32'h5A5A_5A5A, 1'b1, acc},
            '{1'b0, 31'd255,        32'h0000_0001, 1'b1, acc},
            '{1'b0, 31'd256,        32'h0000_0002, 1'b1, acc},
            '{1'b0, 31'h5555_5555,  32'h2AAA_AAAA, 1'b1, acc},
            '{1'b0, 31'h2AAA_AAAA,  32'h5555_5555, 1'b1, acc},
            '{1'b1, 31'd0,          32'h0,         1'b0, none},
            '{1'b1, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b0, none},
            '{1'b0, 31'd0,          32'h0000_0003, 1'b0, none},
            '{1'b1, 31'd0,          32'h0,         1'b0, none},
            '{1'b0, 31'd2,          32'h0000_0004, 1'b0, none},
            '{1'b0, 31'd2,          32'h0000_0005, 1'b0, none},
            '{1'b1, 31'd0,          32'h0,         1'b0, none},
            '{1'b1, 31'd0,          32'h0,         1'b0, none},
            '{1'b1, 31'd0,          32'h0,         1'b0, none}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            r = rows[i];
            it.kind = r.kind;
            it.delay = r.delay;
            it.tag = r.tag;
            send_word(it, r.typed, r.want);
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            case (i * 4 / RAND_ITEMS)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 50; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 50; end
                default: begin snd_idle = 24; rcv_stall = 24; end
            endcase
            if ((i % 100) >= 85)
            begin
                snd_idle = 0;
                rcv_stall = 0;
            end
            it.kind = ($urandom_range(99) < 65);
            it.tag = $urandom();
            roll = $urandom_range(99);
            if (roll < 80)
                it.delay = 31'($urandom_range(700));
            else if (roll < 95)
                it.delay = 31'($urandom_range(20000));
            else
                it.delay = 31'($urandom());
            send_word(it, 1'b0, none);
        end

        snd_idle = 24;
        rcv_stall = 24;
        for (int i = 0; i < BURST; i++)
        begin
            it.kind = 1'b0;
            it.tag = $urandom();
            it.delay = 31'($urandom_range(32'h7FFF_FFFF, 100000));
            send_word(it, 1'b0, none);
        end
        req.valid <= 1'b0;

        wait (due_q.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
